### rtl/cfla_pkg.sv
// cfla_pkg: shared constants and command codes for the chunked free-list allocator
// depends on nothing; used by chunked_free_list_allocator and the bench
package cfla_pkg;

   localparam int BLOCKS_PER_CHUNK = 64;
   localparam int MAX_CHUNKS       = 16;
   localparam int POOL_BLOCKS      = MAX_CHUNKS * BLOCKS_PER_CHUNK;

   localparam int ADDR_W  = $clog2(POOL_BLOCKS);
   localparam int LINK_W  = ADDR_W + 1;
   localparam int BLK_W   = (BLOCKS_PER_CHUNK > 1) ? $clog2(BLOCKS_PER_CHUNK) : 1;
   localparam int CHUNK_W = 5;
   localparam int COUNT_W = 11;
   localparam int CMD_W   = 2;

   localparam logic [LINK_W-1:0]  NULL_MARK = LINK_W'(POOL_BLOCKS);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;
   localparam logic [CMD_W-1:0] CMD_STATS = 2'd3;

endpackage

### rtl/cfla_ram.sv
// cfla_ram: generic single-write, single-read RAM with registered read data
// no package dependencies
module cfla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/chunked_free_list_allocator.sv
// chunked_free_list_allocator: fixed-size block pool on a lifo free list
// depends on cfla_pkg and cfla_ram (link memory)
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_cmd, req_block_index
//   rsp      out        rsp_valid/rsp_ready    granted_index, status, four counts
//   csr      in         csr_valid/csr_ready    csr_chunk_limit (always ready)
//
// free and stats: accept, done; allocate from a non-empty list: accept, pop_wait, done
// allocate adding a chunk: push, pop_rd, pop_wait, done; one link write per cycle in push
// reset command: same push unit walking every chunk in use, newest first, then done
// one item at a time; the next item is taken once the result sits in the output register
// a stalled rsp holds the result and the block waits in its done state
// synchronous reset clears the list head and counts and sets the limit to MAX_CHUNKS; link memory is not cleared
module chunked_free_list_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cfla_pkg::CMD_W-1:0]       req_cmd,
   input  logic [cfla_pkg::ADDR_W-1:0]      req_block_index,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cfla_pkg::ADDR_W-1:0]      rsp_granted_index,
   output logic                             rsp_status,
   output logic [cfla_pkg::COUNT_W-1:0]     rsp_total_blocks,
   output logic [cfla_pkg::COUNT_W-1:0]     rsp_used_blocks,
   output logic [cfla_pkg::COUNT_W-1:0]     rsp_free_blocks,
   output logic [cfla_pkg::CHUNK_W-1:0]     rsp_chunks_in_use,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cfla_pkg::CHUNK_W-1:0]     csr_chunk_limit
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_POP_RD,
      ST_POP_WAIT,
      ST_DONE
   } state_type;

   state_type                         state_ff, state_in;
   logic [cfla_pkg::CMD_W-1:0]        cmd_ff, cmd_in;
   logic [cfla_pkg::CHUNK_W-1:0]      chunk_ff, chunk_in;
   logic [cfla_pkg::BLK_W-1:0]        blk_ff, blk_in;
   logic [cfla_pkg::LINK_W-1:0]       head_ff, head_in;
   logic [cfla_pkg::CHUNK_W-1:0]      chunk_cnt_ff, chunk_cnt_in;
   logic [cfla_pkg::COUNT_W-1:0]      used_ff, used_in;
   logic [cfla_pkg::COUNT_W-1:0]      free_ff, free_in;
   logic [cfla_pkg::CHUNK_W-1:0]      limit_ff, limit_in;
   logic [cfla_pkg::ADDR_W-1:0]       granted_ff, granted_in;
   logic                              fail_ff, fail_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [cfla_pkg::ADDR_W-1:0]       rsp_granted_ff, rsp_granted_in;
   logic                              rsp_status_ff, rsp_status_in;
   logic [cfla_pkg::COUNT_W-1:0]      rsp_total_ff, rsp_total_in;
   logic [cfla_pkg::COUNT_W-1:0]      rsp_used_ff, rsp_used_in;
   logic [cfla_pkg::COUNT_W-1:0]      rsp_free_ff, rsp_free_in;
   logic [cfla_pkg::CHUNK_W-1:0]      rsp_chunks_ff, rsp_chunks_in;

   logic                              mem_we;
   logic [cfla_pkg::ADDR_W-1:0]       mem_waddr;
   logic [cfla_pkg::LINK_W-1:0]       mem_wdata;
   logic                              mem_re;
   logic [cfla_pkg::ADDR_W-1:0]       mem_raddr;
   logic [cfla_pkg::LINK_W-1:0]       mem_rdata;

   logic                              req_fire;
   logic [cfla_pkg::COUNT_W-1:0]      total;
   logic                              can_grow;
   logic [cfla_pkg::ADDR_W-1:0]       push_addr;
   logic                              blk_last;
   logic [cfla_pkg::COUNT_W:0]        free_plus_chunk;

   cfla_ram #(
      .WIDTH(cfla_pkg::LINK_W),
      .DEPTH(cfla_pkg::POOL_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign total    = cfla_pkg::COUNT_W'(chunk_cnt_ff * cfla_pkg::BLOCKS_PER_CHUNK);
   assign can_grow = (chunk_cnt_ff < limit_ff) &&
                     (chunk_cnt_ff < cfla_pkg::CHUNK_W'(cfla_pkg::MAX_CHUNKS));
   // block number of the push unit: chunk * blocks_per_chunk + block
   assign push_addr = cfla_pkg::ADDR_W'(chunk_ff * cfla_pkg::BLOCKS_PER_CHUNK) +
                      cfla_pkg::ADDR_W'(blk_ff);
   assign blk_last  = (blk_ff == cfla_pkg::BLK_W'(cfla_pkg::BLOCKS_PER_CHUNK - 1));
   assign free_plus_chunk = {1'b0, free_ff} +
                            (cfla_pkg::COUNT_W + 1)'(cfla_pkg::BLOCKS_PER_CHUNK);

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      chunk_in       = chunk_ff;
      blk_in         = blk_ff;
      head_in        = head_ff;
      chunk_cnt_in   = chunk_cnt_ff;
      used_in        = used_ff;
      free_in        = free_ff;
      limit_in       = limit_ff;
      granted_in     = granted_ff;
      fail_in        = fail_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_used_in    = rsp_used_ff;
      rsp_free_in    = rsp_free_ff;
      rsp_chunks_in  = rsp_chunks_ff;
      mem_we         = 1'b0;
      mem_waddr      = push_addr;
      mem_wdata      = head_ff;
      mem_re         = 1'b0;
      mem_raddr      = head_ff[cfla_pkg::ADDR_W-1:0];

      if (csr_valid && csr_ready) begin
         limit_in = csr_chunk_limit;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in     = req_cmd;
               granted_in = '0;
               fail_in    = 1'b0;
               state_in   = ST_DONE;
               case (req_cmd)
                  cfla_pkg::CMD_ALLOC: begin
                     if (head_ff != cfla_pkg::NULL_MARK) begin
                        mem_re   = 1'b1;
                        state_in = ST_POP_WAIT;
                     end else if (can_grow) begin
                        chunk_in = chunk_cnt_ff;
                        blk_in   = '0;
                        state_in = ST_PUSH;
                     end else begin
                        fail_in = 1'b1;
                     end
                  end
                  cfla_pkg::CMD_FREE: begin
                     if ({1'b0, req_block_index} < total) begin
                        mem_we    = 1'b1;
                        mem_waddr = req_block_index;
                        head_in   = {1'b0, req_block_index};
                        if (used_ff != '0) begin
                           used_in = used_ff - 1'b1;
                        end
                        if (free_ff != cfla_pkg::COUNT_MAX) begin
                           free_in = free_ff + 1'b1;
                        end
                     end
                  end
                  cfla_pkg::CMD_RESET: begin
                     head_in = cfla_pkg::NULL_MARK;
                     used_in = '0;
                     free_in = total;
                     if (chunk_cnt_ff != '0) begin
                        // newest chunk first, so the oldest ends on top
                        chunk_in = chunk_cnt_ff - 1'b1;
                        blk_in   = '0;
                        state_in = ST_PUSH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PUSH: begin
            mem_we  = 1'b1;
            head_in = {1'b0, push_addr};
            blk_in  = cfla_pkg::BLK_W'(blk_ff + 1'b1);
            if (blk_last) begin
               blk_in = '0;
               if (cmd_ff == cfla_pkg::CMD_ALLOC) begin
                  chunk_cnt_in = chunk_cnt_ff + 1'b1;
                  free_in = (free_plus_chunk > {1'b0, cfla_pkg::COUNT_MAX}) ?
                            cfla_pkg::COUNT_MAX : free_plus_chunk[cfla_pkg::COUNT_W-1:0];
                  state_in = ST_POP_RD;
               end else if (chunk_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  chunk_in = chunk_ff - 1'b1;
               end
            end
         end
         ST_POP_RD: begin
            mem_re   = 1'b1;
            state_in = ST_POP_WAIT;
         end
         ST_POP_WAIT: begin
            granted_in = head_ff[cfla_pkg::ADDR_W-1:0];
            head_in    = mem_rdata;
            if (used_ff != cfla_pkg::COUNT_MAX) begin
               used_in = used_ff + 1'b1;
            end
            if (free_ff != '0) begin
               free_in = free_ff - 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = granted_ff;
               rsp_status_in  = fail_ff;
               rsp_total_in   = total;
               rsp_used_in    = used_ff;
               rsp_free_in    = free_ff;
               rsp_chunks_in  = chunk_cnt_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= cfla_pkg::NULL_MARK;
         chunk_cnt_ff <= '0;
         used_ff      <= '0;
         free_ff      <= '0;
         limit_ff     <= cfla_pkg::CHUNK_W'(cfla_pkg::MAX_CHUNKS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         chunk_cnt_ff <= chunk_cnt_in;
         used_ff      <= used_in;
         free_ff      <= free_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      chunk_ff       <= chunk_in;
      blk_ff         <= blk_in;
      granted_ff     <= granted_in;
      fail_ff        <= fail_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_used_ff    <= rsp_used_in;
      rsp_free_ff    <= rsp_free_in;
      rsp_chunks_ff  <= rsp_chunks_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_total_blocks  = rsp_total_ff;
   assign rsp_used_blocks   = rsp_used_ff;
   assign rsp_free_blocks   = rsp_free_ff;
   assign rsp_chunks_in_use = rsp_chunks_ff;

   // list head is a real block or the null marker, never beyond
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= cfla_pkg::NULL_MARK)
      else $error("free list head out of range");

   a_chunk_range: assert property (@(posedge clock) disable iff (reset)
      chunk_cnt_ff <= cfla_pkg::CHUNK_W'(cfla_pkg::MAX_CHUNKS))
      else $error("chunk count above pool size");

   // a failed allocate hands out no block
   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> rsp_granted_ff == '0)
      else $error("failed allocate carries a block index");

   // a result is only loaded from the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(state_ff == ST_DONE))
      else $error("result appeared outside done state");

   // the push unit never walks outside the pool
   a_push_in_pool: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PUSH |-> chunk_ff < cfla_pkg::CHUNK_W'(cfla_pkg::MAX_CHUNKS))
      else $error("push walk outside the pool");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for chunked_free_list_allocator, with an in-bench pool predictor
// directed table first, then random alloc/free/reset/stats traffic under several chunk limits
// depends on cfla_pkg and the allocator rtl
module tb;

   localparam int WATCHDOG_CYCLES = 5000;
   localparam int HOLD_CYCLES     = 400;
   localparam int HOLD_AT_REPLY   = 500;
   localparam int DRAIN_CYCLES    = 40;

   typedef struct packed {
      logic [cfla_pkg::ADDR_W-1:0]  granted;
      logic                         status;
      logic [cfla_pkg::COUNT_W-1:0] total;
      logic [cfla_pkg::COUNT_W-1:0] used;
      logic [cfla_pkg::COUNT_W-1:0] free;
      logic [cfla_pkg::CHUNK_W-1:0] chunks;
   } pool_reply_type;

   localparam pool_reply_type NO_REPLY = '0;

   typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_type;

   typedef struct {
      row_kind_type                 kind;
      logic [cfla_pkg::CMD_W-1:0]   cmd;
      logic [cfla_pkg::ADDR_W-1:0]  index;
      logic [cfla_pkg::CHUNK_W-1:0] limit;
      bit                           typed;
      pool_reply_type               want;
   } plan_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid;
   logic                          req_ready;
   logic [cfla_pkg::CMD_W-1:0]    req_cmd;
   logic [cfla_pkg::ADDR_W-1:0]   req_block_index;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [cfla_pkg::ADDR_W-1:0]   rsp_granted_index;
   logic                          rsp_status;
   logic [cfla_pkg::COUNT_W-1:0]  rsp_total_blocks;
   logic [cfla_pkg::COUNT_W-1:0]  rsp_used_blocks;
   logic [cfla_pkg::COUNT_W-1:0]  rsp_free_blocks;
   logic [cfla_pkg::CHUNK_W-1:0]  rsp_chunks_in_use;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [cfla_pkg::CHUNK_W-1:0]  csr_chunk_limit;

   // predicted pool state
   logic [cfla_pkg::LINK_W-1:0]   pool_links [cfla_pkg::POOL_BLOCKS];
   logic [cfla_pkg::LINK_W-1:0]   pool_head;
   logic [cfla_pkg::CHUNK_W-1:0]  pool_chunks;
   logic [cfla_pkg::COUNT_W-1:0]  pool_used;
   logic [cfla_pkg::COUNT_W-1:0]  pool_free;
   logic [cfla_pkg::CHUNK_W-1:0]  pool_limit;

   pool_reply_type      replies_due [$];
   plan_row_type        plan [$];

   int n_items;
   int n_replies;
   int n_limit_fail;
   int n_limit_writes;
   int n_fail;
   int peak_free;
   int idle_cycles;
   int req_gap;

   chunked_free_list_allocator i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_block_index   (req_block_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_granted_index (rsp_granted_index),
      .rsp_status        (rsp_status),
      .rsp_total_blocks  (rsp_total_blocks),
      .rsp_used_blocks   (rsp_used_blocks),
      .rsp_free_blocks   (rsp_free_blocks),
      .rsp_chunks_in_use (rsp_chunks_in_use),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_chunk_limit   (csr_chunk_limit)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [cfla_pkg::COUNT_W-1:0] sat_add(
         logic [cfla_pkg::COUNT_W-1:0] v, int n);
      int sum;
      sum = int'(v) + n;
      return (sum > int'(cfla_pkg::COUNT_MAX)) ? cfla_pkg::COUNT_MAX :
                                                 cfla_pkg::COUNT_W'(sum);
   endfunction

   // blocks 0..B-1 of chunk c go on in order, so block B-1 ends up on top
   function automatic void push_chunk(int c);
      for (int i = 0; i < cfla_pkg::BLOCKS_PER_CHUNK; i++) begin
         pool_links[c * cfla_pkg::BLOCKS_PER_CHUNK + i] = pool_head;
         pool_head = cfla_pkg::LINK_W'(c * cfla_pkg::BLOCKS_PER_CHUNK + i);
      end
   endfunction

   function automatic pool_reply_type pool_predict(logic [cfla_pkg::CMD_W-1:0] cmd,
                                                   logic [cfla_pkg::ADDR_W-1:0] index);
      pool_reply_type r;
      int             lim;
      int             total;
      r = '0;
      total = int'(pool_chunks) * cfla_pkg::BLOCKS_PER_CHUNK;
      case (cmd)
         cfla_pkg::CMD_ALLOC: begin
            if (int'(pool_head) >= cfla_pkg::POOL_BLOCKS) begin
               lim = (int'(pool_limit) < cfla_pkg::MAX_CHUNKS) ? int'(pool_limit) :
                                                                 cfla_pkg::MAX_CHUNKS;
               if (int'(pool_chunks) < lim) begin
                  push_chunk(int'(pool_chunks));
                  pool_chunks = pool_chunks + 1'b1;
                  pool_free = sat_add(pool_free, cfla_pkg::BLOCKS_PER_CHUNK);
               end
            end
            if (int'(pool_head) < cfla_pkg::POOL_BLOCKS) begin
               r.granted = cfla_pkg::ADDR_W'(pool_head);
               pool_head = pool_links[pool_head[cfla_pkg::ADDR_W-1:0]];
               pool_used = sat_add(pool_used, 1);
               if (pool_free != 0) pool_free = pool_free - 1'b1;
            end else begin
               r.status = 1'b1;
            end
         end
         cfla_pkg::CMD_FREE: begin
            // unchecked push; indexes past the added chunks are dropped
            if (int'(index) < total) begin
               pool_links[index] = pool_head;
               pool_head = cfla_pkg::LINK_W'(index);
               if (pool_used != 0) pool_used = pool_used - 1'b1;
               pool_free = sat_add(pool_free, 1);
            end
         end
         cfla_pkg::CMD_RESET: begin
            pool_head = cfla_pkg::NULL_MARK;
            pool_used = '0;
            for (int c = int'(pool_chunks) - 1; c >= 0; c--) push_chunk(c);
            pool_free = sat_add('0, total);
         end
         default: ;
      endcase
      r.total  = cfla_pkg::COUNT_W'(int'(pool_chunks) * cfla_pkg::BLOCKS_PER_CHUNK);
      r.used   = pool_used;
      r.free   = pool_free;
      r.chunks = pool_chunks;
      return r;
   endfunction

   function automatic pool_reply_type reply(int granted, int status, int total, int used,
                                            int free_n, int chunks);
      pool_reply_type r;
      r.granted = cfla_pkg::ADDR_W'(granted);
      r.status  = status[0];
      r.total   = cfla_pkg::COUNT_W'(total);
      r.used    = cfla_pkg::COUNT_W'(used);
      r.free    = cfla_pkg::COUNT_W'(free_n);
      r.chunks  = cfla_pkg::CHUNK_W'(chunks);
      return r;
   endfunction

   // one run of 32 items in every three has no idling
   function automatic int draw_gap(int seq);
      if ((seq / 32) % 3 == 1) return 0;
      return $urandom_range(0, 4);
   endfunction

   function automatic logic [cfla_pkg::CMD_W-1:0] pick_cmd(int alloc_pct, int free_pct,
                                                           int reset_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) return cfla_pkg::CMD_ALLOC;
      if (roll < alloc_pct + free_pct) return cfla_pkg::CMD_FREE;
      if (roll < alloc_pct + free_pct + reset_pct) return cfla_pkg::CMD_RESET;
      return cfla_pkg::CMD_STATS;
   endfunction

   function automatic logic [cfla_pkg::ADDR_W-1:0] pick_index(int in_pool_pct);
      int total;
      total = int'(pool_chunks) * cfla_pkg::BLOCKS_PER_CHUNK;
      if (total > 0 && $urandom_range(0, 99) < in_pool_pct)
         return cfla_pkg::ADDR_W'($urandom_range(0, total - 1));
      return cfla_pkg::ADDR_W'($urandom);
   endfunction

   function automatic void check_field(string name, logic [cfla_pkg::COUNT_W-1:0] want,
                                       logic [cfla_pkg::COUNT_W-1:0] got);
      if (got !== want) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
         n_fail++;
      end
   endfunction

   task automatic send_item(input logic [cfla_pkg::CMD_W-1:0] cmd,
                            input logic [cfla_pkg::ADDR_W-1:0] index,
                            input bit typed, input pool_reply_type want);
      pool_reply_type due;
      if (req_gap > 0) repeat (req_gap) @(posedge clock);
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_block_index <= index;
      do @(posedge clock); while (!req_ready);
      due = pool_predict(cmd, index);
      n_items++;
      if (due.status) n_limit_fail++;
      if (int'(pool_free) > peak_free) peak_free = int'(pool_free);
      if (typed) due = want;
      replies_due.push_back(due);
      req_gap = draw_gap(n_items);
      // valid stays up when the next item follows at once
      if (req_gap > 0) req_valid <= 1'b0;
   endtask

   task automatic send_random(input int alloc_pct, input int free_pct, input int reset_pct,
                              input int in_pool_pct);
      send_item(pick_cmd(alloc_pct, free_pct, reset_pct), pick_index(in_pool_pct),
                1'b0, NO_REPLY);
   endtask

   task automatic wait_idle();
      if (req_gap == 0) req_valid <= 1'b0;
      req_gap = 0;
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_chunk_limit(input logic [cfla_pkg::CHUNK_W-1:0] value);
      wait_idle();
      repeat (4) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_chunk_limit <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pool_limit = value;
      n_limit_writes++;
   endtask

   // reply checker and watchdog
   always @(posedge clock) begin
      pool_reply_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            n_replies++;
            if (replies_due.size() == 0) begin
               $display("%0t reply with nothing due: granted %0d total %0d", $time,
                        rsp_granted_index, rsp_total_blocks);
               n_fail++;
            end else begin
               want = replies_due.pop_front();
               check_field("granted_index", cfla_pkg::COUNT_W'(want.granted),
                           cfla_pkg::COUNT_W'(rsp_granted_index));
               check_field("status", cfla_pkg::COUNT_W'(want.status),
                           cfla_pkg::COUNT_W'(rsp_status));
               check_field("total_blocks", want.total, rsp_total_blocks);
               check_field("used_blocks", want.used, rsp_used_blocks);
               check_field("free_blocks", want.free, rsp_free_blocks);
               check_field("chunks_in_use", cfla_pkg::COUNT_W'(want.chunks),
                           cfla_pkg::COUNT_W'(rsp_chunks_in_use));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t no item moved for %0d cycles", $time, idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // result side: random stalls plus one long hold-off so the block backs up
   initial begin
      int gap;
      bit held;
      held = 1'b0;
      rsp_ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(n_replies);
         if (!held && n_replies >= HOLD_AT_REPLY) begin
            gap  = HOLD_CYCLES;
            held = 1'b1;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int grow_limits [3];
      int guard;
      int fails_at_start;
      int extra;
      req_valid       <= 1'b0;
      req_cmd         <= cfla_pkg::CMD_STATS;
      req_block_index <= '0;
      csr_valid       <= 1'b0;
      csr_chunk_limit <= '0;
      pool_head       = cfla_pkg::NULL_MARK;
      pool_chunks     = '0;
      pool_used       = '0;
      pool_free       = '0;
      pool_limit      = 5'd16;
      req_gap         = 0;

      // empty pool, limit at zero, out-of-pool frees, then the first chunk
      plan.push_back('{ROW_ITEM, cfla_pkg::CMD_STATS, 10'd1023, 5'd0, 1'b1,
                       reply(0, 0, 0, 0, 0, 0)});
      plan.push_back('{ROW_LIMIT, cfla_pkg::CMD_STATS, 10'd0, 5'd0, 1'b0, NO_REPLY});
      plan.push_back('{ROW_ITEM, cfla_pkg::CMD_ALLOC, 10'd0, 5'd0, 1'b1,
                       reply(0, 1, 0, 0, 0, 0)});
      plan.push_back('{ROW_ITEM, cfla_pkg::CMD_STATS, 10'd0, 5'd0, 1'b1,
                       reply(0, 0, 0, 0, 0, 0)});
      plan.push_back('{ROW_ITEM, cfla_pkg::CMD_FREE, 10'd0, 5'd0, 1'b1,
                       reply(0, 0, 0, 0, 0, 0)});
      plan.push_back('{ROW_ITEM, cfla_pkg::CMD_FREE, 10'd1023, 5'd0, 1'b1,
                       reply(0, 0, 0, 0, 0, 0)});
      plan.push_back('{ROW_ITEM, cfla_pkg::CMD_RESET, 10'd0, 5'd0, 1'b1,
                       reply(0, 0, 0, 0, 0, 0)});
      plan.push_back('{ROW_LIMIT, cfla_pkg::CMD_STATS, 10'd0, 5'd1, 1'b0, NO_REPLY});
      plan.push_back('{ROW_ITEM, cfla_pkg::CMD_ALLOC, 10'd1023, 5'd0, 1'b1,
                       reply(63, 0, 64, 1, 63, 1)});
      plan.push_back('{ROW_ITEM, cfla_pkg::CMD_ALLOC, 10'd0, 5'd0, 1'b0, NO_REPLY});
      plan.push_back('{ROW_ITEM, cfla_pkg::CMD_FREE, 10'd63, 5'd0, 1'b0, NO_REPLY});
      plan.push_back('{ROW_ITEM, cfla_pkg::CMD_FREE, 10'd63, 5'd0, 1'b0, NO_REPLY});
      plan.push_back('{ROW_ITEM, cfla_pkg::CMD_FREE, 10'd64, 5'd0, 1'b0, NO_REPLY});
      plan.push_back('{ROW_ITEM, cfla_pkg::CMD_FREE, 10'd1023, 5'd0, 1'b0, NO_REPLY});
      plan.push_back('{ROW_ITEM, cfla_pkg::CMD_RESET, 10'd1023, 5'd0, 1'b1,
                       reply(0, 0, 64, 0, 64, 1)});
      // free with nothing handed out: used count stays at zero
      plan.push_back('{ROW_ITEM, cfla_pkg::CMD_FREE, 10'd0, 5'd0, 1'b1,
                       reply(0, 0, 64, 0, 65, 1)});
      plan.push_back('{ROW_ITEM, cfla_pkg::CMD_STATS, 10'd512, 5'd0, 1'b0, NO_REPLY});
      plan.push_back('{ROW_ITEM, cfla_pkg::CMD_ALLOC, 10'd0, 5'd0, 1'b0, NO_REPLY});
      plan.push_back('{ROW_ITEM, cfla_pkg::CMD_ALLOC, 10'd0, 5'd0, 1'b0, NO_REPLY});
      plan.push_back('{ROW_LIMIT, cfla_pkg::CMD_STATS, 10'd0, 5'd31, 1'b0, NO_REPLY});
      plan.push_back('{ROW_ITEM, cfla_pkg::CMD_STATS, 10'd0, 5'd0, 1'b0, NO_REPLY});
      plan.push_back('{ROW_ITEM, cfla_pkg::CMD_ALLOC, 10'd0, 5'd0, 1'b0, NO_REPLY});

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[k]) begin
         if (plan[k].kind == ROW_LIMIT)
            write_chunk_limit(plan[k].limit);
         else
            send_item(plan[k].cmd, plan[k].index, plan[k].typed, plan[k].want);
      end

      // grow the pool step by step, running into each limit a few times
      grow_limits = '{3, 9, 16};
      foreach (grow_limits[k]) begin
         write_chunk_limit(cfla_pkg::CHUNK_W'(grow_limits[k]));
         fails_at_start = n_limit_fail;
         guard = 0;
         while (!(int'(pool_chunks) == grow_limits[k] && n_limit_fail - fails_at_start >= 3)
                && guard < 2500) begin
            send_random(88, 10, 0, 70);
            guard++;
         end
      end

      // limit dropped below the chunks already added, then a random one
      write_chunk_limit(5'd2);
      repeat (100) send_random(40, 40, 4, 80);
      write_chunk_limit(cfla_pkg::CHUNK_W'($urandom_range(0, 31)));
      repeat (100) send_random(45, 35, 4, 80);

      // refill, then pile on frees until the free count pins at its ceiling
      write_chunk_limit(5'd31);
      send_item(cfla_pkg::CMD_RESET, cfla_pkg::ADDR_W'($urandom), 1'b0, NO_REPLY);
      extra = 0;
      guard = 0;
      while (extra < 30 && guard < 3000) begin
         send_random(3, 95, 0, 97);
         if (pool_free == cfla_pkg::COUNT_MAX) extra++;
         guard++;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("ran %0d items and %0d replies over %0d limit settings, %0d refused allocs",
               n_items, n_replies, n_limit_writes, n_limit_fail);
      $display("pool reached %0d chunks, free count peaked at %0d", pool_chunks, peak_free);
      if (n_fail == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
